@@ rtl/dau_pkg.sv @@
// shared constants, types and the cordic angle table of the dihedral angle unit
package dau_pkg;

   localparam int COORD_WIDTH_DEF  = 24;
   localparam int CORDIC_STEPS_DEF = 18;

   // coordinates wider than this are pre-shifted
   localparam int PRE_LIMIT = 25;

   // normal vectors are scaled below 2^NORM_BITS
   localparam int NORM_BITS = 23;
   localparam int NORM_W    = NORM_BITS + 1;

   // cross product and dot product of the scaled normals
   localparam int WD_W    = 2 * NORM_W + 2;
   localparam int WD_BITS = 30;
   localparam int WD_KW   = $clog2(WD_W + 1);

   // sum of squares and its root
   localparam int SQ_W   = 2 * WD_BITS + 2;
   localparam int ROOT_W = WD_BITS + 1;

   // cordic datapath
   localparam int XC_W = WD_BITS + 4;
   localparam int Z_W  = 26;
   localparam logic signed [Z_W-1:0] DEG_90  = Z_W'(90 * 65536);
   localparam logic signed [Z_W-1:0] DEG_180 = Z_W'(180 * 65536);
   localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(256);
   localparam int ANG_SHIFT = 9;

   // result
   localparam int ANG_W   = 16;
   localparam int ANG_MAX = 23040;

   typedef logic signed [NORM_W-1:0] norm_type;

   typedef struct packed {
      logic [SQ_W-1:0]          sq;
      logic signed [WD_BITS:0]  x;
      logic                     spos;
      logic                     degen;
   } root_job_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        y;
      logic signed [WD_BITS:0]  x;
      logic                     spos;
      logic                     degen;
   } cordic_job_type;

   typedef struct packed {
      logic signed [ANG_W-1:0]  angle;
      logic                     degenerate;
   } result_type;

   // atan(2^-i) in units of 2^-16 degree
   function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return Z_W'(signed'({1'b0, v}));
   endfunction

endpackage

@@ rtl/dau_stream_if.sv @@
// request and response stream interfaces of the dihedral angle unit
interface dau_req_if #(
   parameter int COORD_WIDTH = dau_pkg::COORD_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
   logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
   logic signed [COORD_WIDTH-1:0] p3_x, p3_y, p3_z;
   logic signed [COORD_WIDTH-1:0] p4_x, p4_y, p4_z;

   modport source (
      output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
             p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
      input  ready
   );
   modport sink (
      input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
             p3_x, p3_y, p3_z, p4_x, p4_y, p4_z,
      output ready
   );
endinterface

interface dau_rsp_if;
   import dau_pkg::*;
   logic valid;
   logic ready;
   logic signed [ANG_W-1:0] angle;
   logic degenerate;

   modport source (output valid, angle, degenerate, input ready);
   modport sink (input valid, angle, degenerate, output ready);
endinterface

@@ rtl/dau_norm.sv @@
// front pipeline: bond vectors, normals u and v, collinear check and normal scaling
module dau_norm #(
   parameter int COORD_WIDTH = dau_pkg::COORD_WIDTH_DEF,
   localparam int DIFF_W = (COORD_WIDTH > dau_pkg::PRE_LIMIT) ?
                           dau_pkg::PRE_LIMIT + 1 : COORD_WIDTH + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   dau_req_if.sink                  req_bus,
   output logic                     out_valid,
   output dau_pkg::norm_type        u_out [3],
   output dau_pkg::norm_type        v_out [3],
   output logic signed [DIFF_W-1:0] db_out [3],
   output logic                     degen_out
);
   import dau_pkg::*;

   localparam int PRE_SHIFT = (COORD_WIDTH > PRE_LIMIT) ? COORD_WIDTH - PRE_LIMIT : 0;
   localparam int FULL_W    = COORD_WIDTH + 1;
   localparam int CROSS_W   = 2 * DIFF_W + 1;
   localparam int KW        = $clog2(CROSS_W + 1);
   localparam int STAGES    = 5;

   // difference with truncating pre-shift
   function automatic logic signed [DIFF_W-1:0] diff_pre(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [FULL_W-1:0] d;
      logic [FULL_W-1:0]        m;
      logic [DIFF_W-1:0]        t;
      d = FULL_W'(a) - FULL_W'(b);
      m = d[FULL_W-1] ? FULL_W'(-d) : FULL_W'(d);
      m = m >> PRE_SHIFT;
      t = m[DIFF_W-1:0];
      return d[FULL_W-1] ? DIFF_W'(-t) : DIFF_W'(t);
   endfunction

   // one cross product component a1*b2 - a2*b1
   function automatic logic signed [CROSS_W-1:0] cross_term(
      input logic signed [DIFF_W-1:0] a1,
      input logic signed [DIFF_W-1:0] b2,
      input logic signed [DIFF_W-1:0] a2,
      input logic signed [DIFF_W-1:0] b1
   );
      logic signed [2*DIFF_W-1:0] m0, m1;
      m0 = a1 * b2;
      m1 = a2 * b1;
      return CROSS_W'(m0) - CROSS_W'(m1);
   endfunction

   // right shift that brings the largest magnitude below the normal limit
   function automatic logic [KW-1:0] shift_for(
      input logic [CROSS_W-1:0] a,
      input logic [CROSS_W-1:0] b,
      input logic [CROSS_W-1:0] c
   );
      logic [CROSS_W-1:0] o;
      logic [KW-1:0]      len;
      o   = a | b | c;
      len = '0;
      for (int i = 0; i < CROSS_W; i++) begin
         if (o[i]) len = KW'(i + 1);
      end
      return (len > KW'(NORM_BITS)) ? len - KW'(NORM_BITS) : '0;
   endfunction

   function automatic norm_type apply_shift(
      input logic [CROSS_W-1:0] m,
      input logic               s,
      input logic [KW-1:0]      k
   );
      logic [CROSS_W-1:0] t;
      logic [NORM_W-1:0]  q;
      t = m >> k;
      q = {1'b0, t[NORM_BITS-1:0]};
      return s ? norm_type'(-q) : norm_type'(q);
   endfunction

   logic signed [COORD_WIDTH-1:0] pa [3], pb [3], pc [3], pd [3];
   logic [STAGES-1:0] vld_ff;

   logic signed [DIFF_W-1:0]  ab1_ff [3], cb1_ff [3], db1_ff [3];
   logic signed [CROSS_W-1:0] u2_ff [3], v2_ff [3];
   logic signed [DIFF_W-1:0]  db2_ff [3], db3_ff [3], db4_ff [3];
   logic [CROSS_W-1:0]        um3_ff [3], vm3_ff [3], um4_ff [3], vm4_ff [3];
   logic [2:0]                us3_ff, vs3_ff, us4_ff, vs4_ff;
   logic                      degen3_ff, degen4_ff, degen5_ff;
   logic [KW-1:0]             uk4_ff, vk4_ff;
   norm_type                  u5_ff [3], v5_ff [3];
   logic signed [DIFF_W-1:0]  db5_ff [3];

   // request beat fields as vectors
   assign pa[0] = req_bus.p1_x;
   assign pa[1] = req_bus.p1_y;
   assign pa[2] = req_bus.p1_z;
   assign pb[0] = req_bus.p2_x;
   assign pb[1] = req_bus.p2_y;
   assign pb[2] = req_bus.p2_z;
   assign pc[0] = req_bus.p3_x;
   assign pc[1] = req_bus.p3_y;
   assign pc[2] = req_bus.p3_z;
   assign pd[0] = req_bus.p4_x;
   assign pd[1] = req_bus.p4_y;
   assign pd[2] = req_bus.p4_z;

   assign req_bus.ready = advance;

   // valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_bus.valid};
      end
   end

   // stage 1: bond vectors
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            ab1_ff[k] <= diff_pre(pa[k], pb[k]);
            cb1_ff[k] <= diff_pre(pc[k], pb[k]);
            db1_ff[k] <= diff_pre(pd[k], pc[k]);
         end
      end
   end

   // stage 2: normals u = ab x cb, v = db x cb
   always_ff @(posedge clock) begin
      if (advance) begin
         u2_ff[0] <= cross_term(ab1_ff[1], cb1_ff[2], ab1_ff[2], cb1_ff[1]);
         u2_ff[1] <= cross_term(ab1_ff[2], cb1_ff[0], ab1_ff[0], cb1_ff[2]);
         u2_ff[2] <= cross_term(ab1_ff[0], cb1_ff[1], ab1_ff[1], cb1_ff[0]);
         v2_ff[0] <= cross_term(db1_ff[1], cb1_ff[2], db1_ff[2], cb1_ff[1]);
         v2_ff[1] <= cross_term(db1_ff[2], cb1_ff[0], db1_ff[0], cb1_ff[2]);
         v2_ff[2] <= cross_term(db1_ff[0], cb1_ff[1], db1_ff[1], cb1_ff[0]);
         db2_ff   <= db1_ff;
      end
   end

   // stage 3: sign and magnitude, collinear check
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            us3_ff[k] <= u2_ff[k][CROSS_W-1];
            vs3_ff[k] <= v2_ff[k][CROSS_W-1];
            um3_ff[k] <= u2_ff[k][CROSS_W-1] ? CROSS_W'(-u2_ff[k]) : CROSS_W'(u2_ff[k]);
            vm3_ff[k] <= v2_ff[k][CROSS_W-1] ? CROSS_W'(-v2_ff[k]) : CROSS_W'(v2_ff[k]);
         end
         degen3_ff <= (u2_ff[0] == '0 && u2_ff[1] == '0 && u2_ff[2] == '0) ||
                      (v2_ff[0] == '0 && v2_ff[1] == '0 && v2_ff[2] == '0);
         db3_ff    <= db2_ff;
      end
   end

   // stage 4: scale shift per normal
   always_ff @(posedge clock) begin
      if (advance) begin
         uk4_ff    <= shift_for(um3_ff[0], um3_ff[1], um3_ff[2]);
         vk4_ff    <= shift_for(vm3_ff[0], vm3_ff[1], vm3_ff[2]);
         um4_ff    <= um3_ff;
         vm4_ff    <= vm3_ff;
         us4_ff    <= us3_ff;
         vs4_ff    <= vs3_ff;
         degen4_ff <= degen3_ff;
         db4_ff    <= db3_ff;
      end
   end

   // stage 5: scaled normals
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            u5_ff[k] <= apply_shift(um4_ff[k], us4_ff[k], uk4_ff);
            v5_ff[k] <= apply_shift(vm4_ff[k], vs4_ff[k], vk4_ff);
         end
         degen5_ff <= degen4_ff;
         db5_ff    <= db4_ff;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign u_out     = u5_ff;
   assign v_out     = v5_ff;
   assign db_out    = db5_ff;
   assign degen_out = degen5_ff;

endmodule

@@ rtl/dau_mag.sv @@
// middle pipeline: w = u x v, d = u . v, sign test, common scaling, sum of squares
module dau_mag #(
   parameter int DIFF_W = dau_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  dau_pkg::norm_type        u_in [3],
   input  dau_pkg::norm_type        v_in [3],
   input  logic signed [DIFF_W-1:0] db_in [3],
   input  logic                     degen_in,
   output logic                     out_valid,
   output dau_pkg::root_job_type    job_out
);
   import dau_pkg::*;

   localparam int PROD_W = 2 * NORM_W;
   localparam int SP_W   = NORM_W + DIFF_W;
   localparam int SS_W   = SP_W + 2;
   localparam int STAGES = 7;

   logic [STAGES-1:0] vld_ff;

   logic signed [PROD_W-1:0] wp1_ff [6], dp1_ff [3];
   logic signed [SP_W-1:0]   sp1_ff [3];
   logic                     degen1_ff, degen2_ff, degen3_ff, degen4_ff, degen5_ff, degen6_ff;
   logic signed [WD_W-1:0]   w2_ff [3], d2_ff;
   logic                     spos2_ff, spos3_ff, spos4_ff, spos5_ff, spos6_ff;
   logic [WD_W-1:0]          wm3_ff [3], dm3_ff, wm4_ff [3], dm4_ff;
   logic                     ds3_ff, ds4_ff;
   logic [WD_KW-1:0]         k4_ff;
   logic [WD_BITS-1:0]       ws5_ff [3];
   logic signed [WD_BITS:0]  x5_ff, x6_ff;
   logic [2*WD_BITS-1:0]     sq6_ff [3];
   root_job_type             job7_ff;

   logic signed [SS_W-1:0]   ssum_in;
   logic                     spos_in;
   logic [WD_W-1:0]          orv_in;
   logic [WD_KW-1:0]         len_in;
   logic [WD_KW-1:0]         k_in;
   logic [WD_W-1:0]          dsh_in;
   logic [WD_BITS:0]         dq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // stage 1: all partial products
   always_ff @(posedge clock) begin
      if (advance) begin
         wp1_ff[0] <= u_in[1] * v_in[2];
         wp1_ff[1] <= u_in[2] * v_in[1];
         wp1_ff[2] <= u_in[2] * v_in[0];
         wp1_ff[3] <= u_in[0] * v_in[2];
         wp1_ff[4] <= u_in[0] * v_in[1];
         wp1_ff[5] <= u_in[1] * v_in[0];
         for (int k = 0; k < 3; k++) begin
            dp1_ff[k] <= u_in[k] * v_in[k];
            sp1_ff[k] <= u_in[k] * db_in[k];
         end
         degen1_ff <= degen_in;
      end
   end

   // sign test u . db > 0
   always_comb begin
      ssum_in = SS_W'(sp1_ff[0]) + SS_W'(sp1_ff[1]) + SS_W'(sp1_ff[2]);
      spos_in = !ssum_in[SS_W-1] && (ssum_in != '0);
   end

   // stage 2: sums
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            w2_ff[k] <= WD_W'(wp1_ff[2*k]) - WD_W'(wp1_ff[2*k+1]);
         end
         d2_ff     <= WD_W'(dp1_ff[0]) + WD_W'(dp1_ff[1]) + WD_W'(dp1_ff[2]);
         spos2_ff  <= spos_in;
         degen2_ff <= degen1_ff;
      end
   end

   // stage 3: magnitudes
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            wm3_ff[k] <= w2_ff[k][WD_W-1] ? WD_W'(-w2_ff[k]) : WD_W'(w2_ff[k]);
         end
         dm3_ff    <= d2_ff[WD_W-1] ? WD_W'(-d2_ff) : WD_W'(d2_ff);
         ds3_ff    <= d2_ff[WD_W-1];
         spos3_ff  <= spos2_ff;
         degen3_ff <= degen2_ff;
      end
   end

   // common shift that brings all four below the limit
   always_comb begin
      orv_in = wm3_ff[0] | wm3_ff[1] | wm3_ff[2] | dm3_ff;
      len_in = '0;
      for (int i = 0; i < WD_W; i++) begin
         if (orv_in[i]) len_in = WD_KW'(i + 1);
      end
      k_in = (len_in > WD_KW'(WD_BITS)) ? len_in - WD_KW'(WD_BITS) : '0;
   end

   // stage 4: shift amount
   always_ff @(posedge clock) begin
      if (advance) begin
         k4_ff     <= k_in;
         wm4_ff    <= wm3_ff;
         dm4_ff    <= dm3_ff;
         ds4_ff    <= ds3_ff;
         spos4_ff  <= spos3_ff;
         degen4_ff <= degen3_ff;
      end
   end

   always_comb begin
      dsh_in = dm4_ff >> k4_ff;
      dq_in  = {1'b0, dsh_in[WD_BITS-1:0]};
   end

   // stage 5: scaled w magnitudes and signed d
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            ws5_ff[k] <= WD_BITS'(wm4_ff[k] >> k4_ff);
         end
         x5_ff     <= ds4_ff ? signed'(-dq_in) : signed'(dq_in);
         spos5_ff  <= spos4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   // stage 6: squares
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            sq6_ff[k] <= ws5_ff[k] * ws5_ff[k];
         end
         x6_ff     <= x5_ff;
         spos6_ff  <= spos5_ff;
         degen6_ff <= degen5_ff;
      end
   end

   // stage 7: sum of squares
   always_ff @(posedge clock) begin
      if (advance) begin
         job7_ff.sq    <= SQ_W'(sq6_ff[0]) + SQ_W'(sq6_ff[1]) + SQ_W'(sq6_ff[2]);
         job7_ff.x     <= x6_ff;
         job7_ff.spos  <= spos6_ff;
         job7_ff.degen <= degen6_ff;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign job_out   = job7_ff;

endmodule

@@ rtl/dau_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module dau_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  dau_pkg::root_job_type   job_in,
   output logic                    out_valid,
   output dau_pkg::cordic_job_type job_out
);
   import dau_pkg::*;

   logic [ROOT_W-1:0]       vld_ff;
   logic [SQ_W-1:0]         rem_ff [ROOT_W];
   logic [SQ_W-1:0]         res_ff [ROOT_W];
   logic signed [WD_BITS:0] x_ff [ROOT_W];
   logic [ROOT_W-1:0]       spos_ff, degen_ff;

   logic [SQ_W-1:0]         rem_src [ROOT_W];
   logic [SQ_W-1:0]         res_src [ROOT_W];
   logic signed [WD_BITS:0] x_src [ROOT_W];
   logic [ROOT_W-1:0]       spos_src, degen_src;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   assign rem_src[0]   = job_in.sq;
   assign res_src[0]   = '0;
   assign x_src[0]     = job_in.x;
   assign spos_src[0]  = job_in.spos;
   assign degen_src[0] = job_in.degen;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - s));
      logic [SQ_W-1:0] trial_in;

      if (s > 0) begin : g_link
         assign rem_src[s]   = rem_ff[s-1];
         assign res_src[s]   = res_ff[s-1];
         assign x_src[s]     = x_ff[s-1];
         assign spos_src[s]  = spos_ff[s-1];
         assign degen_src[s] = degen_ff[s-1];
      end

      assign trial_in = res_src[s] + BIT;

      // restoring root step
      always_ff @(posedge clock) begin
         if (advance) begin
            if (rem_src[s] >= trial_in) begin
               rem_ff[s] <= rem_src[s] - trial_in;
               res_ff[s] <= (res_src[s] >> 1) + BIT;
            end else begin
               rem_ff[s] <= rem_src[s];
               res_ff[s] <= res_src[s] >> 1;
            end
            x_ff[s]     <= x_src[s];
            spos_ff[s]  <= spos_src[s];
            degen_ff[s] <= degen_src[s];
         end
      end
   end

   assign out_valid     = vld_ff[ROOT_W-1];
   assign job_out.y     = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign job_out.x     = x_ff[ROOT_W-1];
   assign job_out.spos  = spos_ff[ROOT_W-1];
   assign job_out.degen = degen_ff[ROOT_W-1];

endmodule

@@ rtl/dau_cordic.sv @@
// pipelined vectoring cordic, one rotation per stage, then clamp, rounding and sign
module dau_cordic #(
   parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  dau_pkg::cordic_job_type job_in,
   output logic                    out_valid,
   output dau_pkg::result_type     res_out
);
   import dau_pkg::*;

   localparam int STAGES = CORDIC_STEPS + 2;

   logic [STAGES-1:0]       vld_ff;
   logic signed [XC_W-1:0]  x_ff [CORDIC_STEPS+1];
   logic signed [XC_W-1:0]  y_ff [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]   z_ff [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]   spos_ff, degen_ff;
   result_type              res_ff;

   logic signed [XC_W-1:0]  xe_in, ye_in;
   logic signed [Z_W-1:0]   zc_in, zr_in;
   logic signed [ANG_W-1:0] r_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign xe_in = XC_W'(job_in.x);
   assign ye_in = XC_W'(signed'({1'b0, job_in.y}));

   // pre-rotation into the right half plane
   always_ff @(posedge clock) begin
      if (advance) begin
         if (job_in.x[WD_BITS]) begin
            x_ff[0] <= ye_in;
            y_ff[0] <= -xe_in;
            z_ff[0] <= DEG_90;
         end else begin
            x_ff[0] <= xe_in;
            y_ff[0] <= ye_in;
            z_ff[0] <= '0;
         end
         spos_ff[0]  <= job_in.spos;
         degen_ff[0] <= job_in.degen;
      end
   end

   // rotation stages
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [Z_W-1:0] ATAN = atan_step(5'(i));
      logic signed [XC_W-1:0] xs_in, ys_in;
      logic                   ypos_in;

      assign xs_in   = x_ff[i] >>> i;
      assign ys_in   = y_ff[i] >>> i;
      assign ypos_in = !y_ff[i][XC_W-1] && (y_ff[i] != '0);

      always_ff @(posedge clock) begin
         if (advance) begin
            if (ypos_in) begin
               x_ff[i+1] <= x_ff[i] + ys_in;
               y_ff[i+1] <= y_ff[i] - xs_in;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys_in;
               y_ff[i+1] <= y_ff[i] + xs_in;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end
            spos_ff[i+1]  <= spos_ff[i];
            degen_ff[i+1] <= degen_ff[i];
         end
      end
   end

   // clamp to 0..180 degrees, round half up to 1/128 degree
   always_comb begin
      if (z_ff[CORDIC_STEPS][Z_W-1]) begin
         zc_in = '0;
      end else if (z_ff[CORDIC_STEPS] > DEG_180) begin
         zc_in = DEG_180;
      end else begin
         zc_in = z_ff[CORDIC_STEPS];
      end
      zr_in = (zc_in + Z_ROUND) >>> ANG_SHIFT;
      r_in  = zr_in[ANG_W-1:0];
   end

   // final stage: sign and collinear override
   always_ff @(posedge clock) begin
      if (advance) begin
         if (degen_ff[CORDIC_STEPS]) begin
            res_ff.angle      <= '0;
            res_ff.degenerate <= 1'b1;
         end else begin
            res_ff.angle      <= spos_ff[CORDIC_STEPS] ? -r_in : r_in;
            res_ff.degenerate <= 1'b0;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign res_out   = res_ff;

endmodule

@@ rtl/dihedral_angle_unit.sv @@
// top level of the dihedral angle unit: pipeline chain and response register
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    p1_x .. p4_z, COORD_WIDTH bits signed each
//   rsp_bus   out  valid/ready    angle (16 bits signed), degenerate (1 bit)
//
// one beat per cycle sustained while the stages are not held; the path includes
// the 31-stage square root and one cordic stage per step.
// synchronous reset clears only the valid bits; no clearing pass.
// all stages move together; they hold while the response register is full and
// not taken and the last stage holds a result, so bubbles still close up.
module dihedral_angle_unit #(
   parameter int COORD_WIDTH  = dau_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   dau_req_if.sink  req_bus,
   dau_rsp_if.source rsp_bus
);
   import dau_pkg::*;

   localparam int DIFF_W = (COORD_WIDTH > PRE_LIMIT) ? PRE_LIMIT + 1 : COORD_WIDTH + 1;

   logic                     advance;
   logic                     norm_vld, mag_vld, root_vld, cord_vld;
   norm_type                 u_s [3], v_s [3];
   logic signed [DIFF_W-1:0] db_s [3];
   logic                     degen_s;
   root_job_type             root_job;
   cordic_job_type           cord_job;
   result_type               cord_res;

   logic                     out_vld_ff;
   result_type               out_ff;
   logic                     out_load;

   assign out_load = !out_vld_ff || rsp_bus.ready;
   assign advance  = out_load || !cord_vld;

   dau_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_bus   (req_bus),
      .out_valid (norm_vld),
      .u_out     (u_s),
      .v_out     (v_s),
      .db_out    (db_s),
      .degen_out (degen_s)
   );

   dau_mag #(.DIFF_W(DIFF_W)) u_mag (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (norm_vld),
      .u_in      (u_s),
      .v_in      (v_s),
      .db_in     (db_s),
      .degen_in  (degen_s),
      .out_valid (mag_vld),
      .job_out   (root_job)
   );

   dau_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mag_vld),
      .job_in    (root_job),
      .out_valid (root_vld),
      .job_out   (cord_job)
   );

   dau_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_vld),
      .job_in    (cord_job),
      .out_valid (cord_vld),
      .res_out   (cord_res)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= cord_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= cord_res;
      end
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.angle      = out_ff.angle;
   assign rsp_bus.degenerate = out_ff.degenerate;

endmodule

@@ rtl/dau_checker.sv @@
// port-level checks of the dihedral angle unit and their bind
module dau_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [dau_pkg::ANG_W-1:0] rsp_angle,
   input logic                           rsp_degenerate
);
   import dau_pkg::*;

   // collinear points give a zero angle
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_angle == '0)
      else $error("degenerate beat with nonzero angle");

   // angle stays within plus or minus 180 degrees
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle >= -ANG_W'(ANG_MAX)) && (rsp_angle <= ANG_W'(ANG_MAX)))
      else $error("angle out of range");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle) && $stable(rsp_degenerate))
      else $error("stalled response beat changed");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dihedral_angle_unit dau_checker u_dau_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_angle      (rsp_bus.angle),
   .rsp_degenerate (rsp_bus.degenerate)
);
